// ===== src/mbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_pkg: shared types and helpers for the maze backtracker carver
// Sequencer states, neighbour directions, stack command beat, pick helpers.
// ----------------------------------------------------------------------------
package mbc_pkg;

    localparam int DEF_GRID_WIDTH  = 32;
    localparam int DEF_GRID_HEIGHT = 32;
    localparam int DEF_STACK_DEPTH = 256;
    localparam int OUT_COORD_W     = 5;
    localparam int RND_W           = 8;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_READ,
        ST_DRAIN,
        ST_PICK,
        ST_PUSH
    } state_t;

    // order matters: candidates are gathered left, right, up, down
    typedef enum logic [1:0] {
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef struct packed {
        logic clr;
        logic push;
        logic pop;
    } stack_cmd_t;

    // value mod 3 via base-4 digit sums (4 == 1 mod 3)
    function automatic logic [1:0] mod3_u8(input logic [RND_W-1:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
        t = 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    function automatic logic [2:0] count4(input logic [3:0] m);
        return 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    endfunction

    // random value modulo the number of candidates
    function automatic logic [1:0] pick_index(input logic [3:0] m,
                                              input logic [RND_W-1:0] rnd);
        logic [1:0] idx;
        unique case (count4(m))
            3'd2:    idx = {1'b0, rnd[0]};
            3'd3:    idx = mod3_u8(rnd);
            3'd4:    idx = rnd[1:0];
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

    // direction of the idx-th set bit of the candidate mask
    function automatic dir_t pick_dir(input logic [3:0] m, input logic [1:0] idx);
        dir_t       d;
        logic [2:0] c;
        d = DIR_LEFT;
        c = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (m[i] && (c == {1'b0, idx}))
            begin
                d = dir_t'(2'(i));
            end
            c = c + 3'(m[i]);
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== src/mbc_bit_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_bit_ram: one-bit-wide cell map memory
// One write and one registered read per cycle, no reset on contents.
// ----------------------------------------------------------------------------
module mbc_bit_ram #(
    parameter int AW = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata
);

    logic mem [0:(2**AW)-1];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/mbc_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_stack: cell coordinate stack
// Memory plus fill level; pop reads the top into an output register,
// a push beyond the depth is dropped.
// ----------------------------------------------------------------------------
module mbc_stack
    import mbc_pkg::*;
#(
    parameter int DEPTH = DEF_STACK_DEPTH,
    parameter int DW    = 10
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire stack_cmd_t    cmd,
    input  wire logic [DW-1:0] wdata,
    output logic [DW-1:0]      rdata,
    output logic               empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = AW + 1;

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [DW-1:0] rdata_reg;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic [LW-1:0] below;
    logic          full;
    logic          wr_en;

    assign full  = (level_reg >= LW'(DEPTH));
    assign empty = (level_reg == '0);
    assign below = level_reg - LW'(1);
    assign wr_en = cmd.push && !full;

    always_comb
    begin
        level_next = level_reg;
        priority if (cmd.clr)
        begin
            level_next = '0;
        end
        else if (wr_en)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (cmd.pop && !empty)
        begin
            level_next = below;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[level_reg[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            rdata_reg <= mem[below[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

`ifndef SYNTH
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(DEPTH))
        else $error("stack level beyond depth");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("stack push and pop in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop && !cmd.clr |=> level_reg == $past(level_reg) - LW'(1))
        else $error("pop did not lower the level");
`endif

endmodule
`default_nettype wire

// ===== src/maze_backtracker_carver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// maze_backtracker_carver: randomised depth-first maze carver
// Wall and visited maps in two bit memories, coordinates on a stack memory,
// driven by one read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a beat is taken when start is high and busy is low.
//   kind selects a new maze (start cell start_x/start_y, forced even) or
//   one carving step (random_value picks among the unvisited candidates).
//   Result channel: done is high for one cycle with the result fields;
//   the receiver cannot stall it, so every result is final when shown.
// Timing
//   Step, stack not empty: stack pop, then ST_FETCH opens the popped
//   cell and marks it visited, ST_READ reads the neighbour visited bit
//   and passage wall bit per direction (one read per memory each cycle),
//   then ST_DRAIN and ST_PICK, which registers done. busy drops with it at
//   a dead end, in the cycle after it after a carve (second stack push).
//   Step, stack empty: done the next cycle, busy never rises.
//   New maze: a clearing pass over 2**(clog2(W)+clog2(H)) map entries
//   (1024 at 32 x 32), one entry a cycle, then done; busy throughout.
// Reset
//   Empties the stack and idles the sequencer. The maps are not cleared:
//   nothing reads them until a new-maze beat has swept them.
// ----------------------------------------------------------------------------
module maze_backtracker_carver
    import mbc_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   kind,
    input  wire logic [4:0]             start_x,
    input  wire logic [4:0]             start_y,
    input  wire logic [RND_W-1:0]       random_value,
    output logic                        done,
    output logic                        running,
    output logic [OUT_COORD_W-1:0]      cell_x,
    output logic [OUT_COORD_W-1:0]      cell_y,
    output logic                        carved,
    output logic [OUT_COORD_W-1:0]      passage_x,
    output logic [OUT_COORD_W-1:0]      passage_y,
    output logic                        true_endpoint
);

    localparam int XW  = $clog2(GRID_WIDTH);
    localparam int YW  = $clog2(GRID_HEIGHT);
    localparam int CAW = XW + YW;   // map address is {y, x}

    // sequencer registers
    state_t           state_reg, state_next;
    logic [CAW-1:0]   cnt_reg, cnt_next;
    logic [XW-1:0]    x_reg, x_next;
    logic [YW-1:0]    y_reg, y_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    dir_t             k_reg, k_next;
    dir_t             capk_reg, capk_next;
    logic             cap_reg, cap_next;
    logic             nin_reg, nin_next;
    logic             ain_reg, ain_next;
    logic [3:0]       cand_reg, cand_next;
    logic [3:0]       open_reg, open_next;

    // result registers
    logic                   done_reg, done_next;
    logic                   running_reg, running_next;
    logic [OUT_COORD_W-1:0] cell_x_reg, cell_x_next;
    logic [OUT_COORD_W-1:0] cell_y_reg, cell_y_next;
    logic                   carved_reg, carved_next;
    logic [OUT_COORD_W-1:0] passage_x_reg, passage_x_next;
    logic [OUT_COORD_W-1:0] passage_y_reg, passage_y_next;
    logic                   endpt_reg, endpt_next;

    // memory ports
    stack_cmd_t     stk_cmd;
    logic [CAW-1:0] stk_rdata;
    logic           stk_empty;
    logic           wall_we, wall_wdata, wall_rdata;
    logic [CAW-1:0] wall_waddr;
    logic           vis_we, vis_wdata, vis_rdata;
    logic [CAW-1:0] vis_waddr;
    logic           ram_re;

    // neighbour geometry
    dir_t           sel;
    dir_t           chosen;
    logic [XW:0]    xe, n_x, a_x;
    logic [YW:0]    ye, n_y, a_y;
    logic           n_in, a_in;
    logic [CAW-1:0] n_addr, a_addr;

    // start cell, reduced into the grid
    logic [8:0]     sx9, sy9;
    logic [XW-1:0]  sx;
    logic [YW-1:0]  sy;

    assign busy = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // Start cell: forced even, reduced modulo grid size, even again
    // ------------------------------------------------------------------
    always_comb
    begin
        sx9 = {4'b0, start_x[4:1], 1'b0};
        sy9 = {4'b0, start_y[4:1], 1'b0};
        for (int i = 0; i < 8; i++)
        begin
            if (sx9 >= 9'(GRID_WIDTH))
            begin
                sx9 = sx9 - 9'(GRID_WIDTH);
            end
            if (sy9 >= 9'(GRID_HEIGHT))
            begin
                sy9 = sy9 - 9'(GRID_HEIGHT);
            end
        end
        sx = {sx9[XW-1:1], 1'b0};
        sy = {sy9[YW-1:1], 1'b0};
    end

    // ------------------------------------------------------------------
    // Cell two away (n_*) and in-between cell (a_*) for one direction.
    // Shared by the read sweep and by the pick.
    // ------------------------------------------------------------------
    assign chosen = pick_dir(cand_reg, pick_index(cand_reg, rnd_reg));
    assign sel    = (state_reg == ST_PICK) ? chosen : k_reg;
    assign xe     = {1'b0, x_reg};
    assign ye     = {1'b0, y_reg};

    always_comb
    begin
        n_x  = xe;
        n_y  = ye;
        a_x  = xe;
        a_y  = ye;
        n_in = 1'b0;
        a_in = 1'b0;
        unique case (sel)
            DIR_LEFT:
            begin
                n_x  = xe - (XW+1)'(2);
                a_x  = xe - (XW+1)'(1);
                n_in = (xe >= (XW+1)'(2));
                a_in = (xe >= (XW+1)'(1));
            end
            DIR_RIGHT:
            begin
                n_x  = xe + (XW+1)'(2);
                a_x  = xe + (XW+1)'(1);
                n_in = (n_x < (XW+1)'(GRID_WIDTH));
                a_in = (a_x < (XW+1)'(GRID_WIDTH));
            end
            DIR_UP:
            begin
                n_y  = ye - (YW+1)'(2);
                a_y  = ye - (YW+1)'(1);
                n_in = (ye >= (YW+1)'(2));
                a_in = (ye >= (YW+1)'(1));
            end
            DIR_DOWN:
            begin
                n_y  = ye + (YW+1)'(2);
                a_y  = ye + (YW+1)'(1);
                n_in = (n_y < (YW+1)'(GRID_HEIGHT));
                a_in = (a_y < (YW+1)'(GRID_HEIGHT));
            end
            default:
            begin
                n_in = 1'b0;
            end
        endcase
    end

    assign n_addr = {n_y[YW-1:0], n_x[XW-1:0]};
    assign a_addr = {a_y[YW-1:0], a_x[XW-1:0]};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rnd_next       = rnd_reg;
        k_next         = k_reg;
        capk_next      = capk_reg;
        cap_next       = 1'b0;
        nin_next       = nin_reg;
        ain_next       = ain_reg;
        cand_next      = cand_reg;
        open_next      = open_reg;
        done_next      = 1'b0;
        running_next   = running_reg;
        cell_x_next    = cell_x_reg;
        cell_y_next    = cell_y_reg;
        carved_next    = carved_reg;
        passage_x_next = passage_x_reg;
        passage_y_next = passage_y_reg;
        endpt_next     = endpt_reg;
        stk_cmd        = '0;
        wall_we        = 1'b0;
        wall_waddr     = cnt_reg;
        wall_wdata     = 1'b1;
        vis_we         = 1'b0;
        vis_waddr      = cnt_reg;
        vis_wdata      = 1'b0;
        ram_re         = 1'b0;

        // read data is registered and lands in the cycle after its address
        if (cap_reg)
        begin
            cand_next[capk_reg] = nin_reg && !vis_rdata;
            open_next[capk_reg] = ain_reg && !wall_rdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rnd_next = random_value;
                    if (kind == KIND_START)
                    begin
                        x_next      = sx;
                        y_next      = sy;
                        cnt_next    = '0;
                        stk_cmd.clr = 1'b1;
                        state_next  = ST_CLEAR;
                    end
                    else if (stk_empty)
                    begin
                        done_next      = 1'b1;
                        running_next   = 1'b0;
                        cell_x_next    = '0;
                        cell_y_next    = '0;
                        carved_next    = 1'b0;
                        passage_x_next = '0;
                        passage_y_next = '0;
                        endpt_next     = 1'b0;
                    end
                    else
                    begin
                        stk_cmd.pop = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_CLEAR:
            begin
                // wall everywhere, nothing visited
                wall_we  = 1'b1;
                vis_we   = 1'b1;
                cnt_next = cnt_reg + CAW'(1);
                if (&cnt_reg)
                begin
                    stk_cmd.push   = 1'b1;
                    done_next      = 1'b1;
                    running_next   = 1'b0;
                    cell_x_next    = '0;
                    cell_y_next    = '0;
                    carved_next    = 1'b0;
                    passage_x_next = '0;
                    passage_y_next = '0;
                    endpt_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                // popped cell: open it and mark it visited
                x_next     = stk_rdata[XW-1:0];
                y_next     = stk_rdata[CAW-1:XW];
                wall_we    = 1'b1;
                wall_waddr = stk_rdata;
                wall_wdata = 1'b0;
                vis_we     = 1'b1;
                vis_waddr  = stk_rdata;
                vis_wdata  = 1'b1;
                k_next     = DIR_LEFT;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_re    = 1'b1;
                cap_next  = 1'b1;
                capk_next = k_reg;
                nin_next  = n_in;
                ain_next  = a_in;
                if (k_reg == DIR_DOWN)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = dir_t'(2'(k_reg) + 2'd1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                done_next    = 1'b1;
                running_next = 1'b1;
                cell_x_next  = OUT_COORD_W'({{OUT_COORD_W{1'b0}}, x_reg});
                cell_y_next  = OUT_COORD_W'({{OUT_COORD_W{1'b0}}, y_reg});
                if (cand_reg != 4'b0)
                begin
                    wall_we        = 1'b1;
                    wall_waddr     = a_addr;
                    wall_wdata     = 1'b0;
                    stk_cmd.push   = 1'b1;          // current cell first
                    x_next         = n_x[XW-1:0];   // then the chosen one
                    y_next         = n_y[YW-1:0];
                    carved_next    = 1'b1;
                    passage_x_next = OUT_COORD_W'({{OUT_COORD_W{1'b0}}, a_x[XW-1:0]});
                    passage_y_next = OUT_COORD_W'({{OUT_COORD_W{1'b0}}, a_y[YW-1:0]});
                    endpt_next     = 1'b0;
                    state_next     = ST_PUSH;
                end
                else
                begin
                    carved_next    = 1'b0;
                    passage_x_next = '0;
                    passage_y_next = '0;
                    endpt_next     = (count4(open_reg) == 3'd1);
                    state_next     = ST_IDLE;
                end
            end
            ST_PUSH:
            begin
                stk_cmd.push = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        rnd_reg       <= rnd_next;
        k_reg         <= k_next;
        capk_reg      <= capk_next;
        nin_reg       <= nin_next;
        ain_reg       <= ain_next;
        cand_reg      <= cand_next;
        open_reg      <= open_next;
        running_reg   <= running_next;
        cell_x_reg    <= cell_x_next;
        cell_y_reg    <= cell_y_next;
        carved_reg    <= carved_next;
        passage_x_reg <= passage_x_next;
        passage_y_reg <= passage_y_next;
        endpt_reg     <= endpt_next;
    end

    assign done          = done_reg;
    assign running       = running_reg;
    assign cell_x        = cell_x_reg;
    assign cell_y        = cell_y_reg;
    assign carved        = carved_reg;
    assign passage_x     = passage_x_reg;
    assign passage_y     = passage_y_reg;
    assign true_endpoint = endpt_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    mbc_stack #(
        .DEPTH (STACK_DEPTH),
        .DW    (CAW)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .wdata ({y_reg, x_reg}),
        .rdata (stk_rdata),
        .empty (stk_empty)
    );

    mbc_bit_ram #(
        .AW (CAW)
    ) u_wall (
        .clk   (clk),
        .we    (wall_we),
        .waddr (wall_waddr),
        .wdata (wall_wdata),
        .re    (ram_re),
        .raddr (a_addr),
        .rdata (wall_rdata)
    );

    mbc_bit_ram #(
        .AW (CAW)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (ram_re),
        .raddr (n_addr),
        .rdata (vis_rdata)
    );

`ifndef SYNTH
    a_carve_no_endpt: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(carved && true_endpoint))
        else $error("carved beat also flagged as endpoint");

    a_carve_running: assert property (@(posedge clk) disable iff (!rst_n)
        done && carved |-> running)
        else $error("carved without a popped cell");

    a_push_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |-> $past(state_reg) == ST_PICK)
        else $error("second push outside a carve");

    a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (kind == KIND_STEP) && stk_empty |=> done && !running)
        else $error("step on empty stack gave no idle result");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for maze_backtracker_carver
// Drives new-maze and carving-step beats, predicts every result from a
// mirror of the wall/visited maps and cell stack, checks each done strobe.
// ----------------------------------------------------------------------------
module tb;
    import mbc_pkg::*;

    localparam int GW         = DEF_GRID_WIDTH;
    localparam int GH         = DEF_GRID_HEIGHT;
    localparam int STK_DEPTH  = DEF_STACK_DEPTH;
    localparam int CELLS      = GW * GH;
    localparam int N_ITEMS    = 1300;
    localparam int N_DIRECTED = 25;
    // a new-maze beat, with its clearing pass and longest gap, costs the most;
    // even if every beat were one, the run stays several times below this
    localparam int LIMIT_CYC  = 5000000;

    // one result beat, field for field as on the ports
    typedef struct packed {
        logic       running;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic       carved;
        logic [4:0] passage_x;
        logic [4:0] passage_y;
        logic       true_endpoint;
    } carve_res_t;

    localparam carve_res_t NO_RES = '0;

    // directed stimulus row; typed rows carry their own expected beat
    typedef struct packed {
        logic       kind;
        logic [4:0] sx;
        logic [4:0] sy;
        logic [7:0] rnd;
        logic       typed;
        carve_res_t want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             kind;
    logic [4:0]       start_x;
    logic [4:0]       start_y;
    logic [RND_W-1:0] random_value;
    logic             done;
    logic             running;
    logic [4:0]       cell_x;
    logic [4:0]       cell_y;
    logic             carved;
    logic [4:0]       passage_x;
    logic [4:0]       passage_y;
    logic             true_endpoint;

    maze_backtracker_carver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .start_x      (start_x),
        .start_y      (start_y),
        .random_value (random_value),
        .done         (done),
        .running      (running),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .carved       (carved),
        .passage_x    (passage_x),
        .passage_y    (passage_y),
        .true_endpoint(true_endpoint)
    );

    // ------------------------------------------------------------------
    // Mirror of the carver state
    // ------------------------------------------------------------------
    bit wall_m  [CELLS];
    bit seen_m  [CELLS];
    int stk_x   [STK_DEPTH];
    int stk_y   [STK_DEPTH];
    int stk_lvl;

    carve_res_t carve_q[$];     // results still owed by the block
    int         mismatches;
    int         beats_sent;
    bit         quiet_run;      // stretch with no sender gaps

    // Directed part: corners, edges, forced-even start cells, random values
    // at the extremes and alternating bit patterns, empty-stack steps.
    dir_row_t dir_rows [0:N_DIRECTED-1] = '{
        // steps with the stack empty straight after reset
        '{KIND_STEP,  5'd0,  5'd0,  8'h00, 1'b1, NO_RES},
        '{KIND_STEP,  5'd31, 5'd31, 8'hFF, 1'b1, NO_RES},
        // far corner; odd start forced to (30,30)
        '{KIND_START, 5'd31, 5'd31, 8'h00, 1'b1, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'hFF, 1'b0, NO_RES},
        '{KIND_STEP,  5'd31, 5'd0,  8'h00, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd31, 8'h80, 1'b0, NO_RES},
        '{KIND_STEP,  5'd21, 5'd10, 8'h7F, 1'b0, NO_RES},
        '{KIND_STEP,  5'd10, 5'd21, 8'h03, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h02, 1'b0, NO_RES},
        // origin corner
        '{KIND_START, 5'd0,  5'd0,  8'hFF, 1'b1, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'hFF, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h00, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h55, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'hAA, 1'b0, NO_RES},
        // odd start in both axes lands on the origin again
        '{KIND_START, 5'd1,  5'd1,  8'h00, 1'b1, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h01, 1'b0, NO_RES},
        // bottom edge
        '{KIND_START, 5'd17, 5'd30, 8'h00, 1'b1, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h02, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h05, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'hFE, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h09, 1'b0, NO_RES},
        // top-right corner
        '{KIND_START, 5'd30, 5'd0,  8'hFF, 1'b1, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h06, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'hC3, 1'b0, NO_RES},
        '{KIND_STEP,  5'd0,  5'd0,  8'h3C, 1'b0, NO_RES}
    };

    function automatic bit in_grid(int x, int y);
        return x >= 0 && x < GW && y >= 0 && y < GH;
    endfunction

    // a push that does not fit is dropped
    function automatic void stack_push(int x, int y);
        if (stk_lvl < STK_DEPTH)
        begin
            stk_x[stk_lvl] = x;
            stk_y[stk_lvl] = y;
            stk_lvl++;
        end
    endfunction

    // Work out the result of one accepted beat and advance the mirror.
    function automatic carve_res_t carve_predict(logic k, logic [4:0] sx,
                                                 logic [4:0] sy, logic [7:0] rnd);
        carve_res_t r;
        int         cx, cy, nx, ny, mx, my;
        int         n_cand, n_open, pick;
        int         cand_x [4];
        int         cand_y [4];
        int         mid_x  [4];
        int         mid_y  [4];
        int         ddx    [4];
        int         ddy    [4];
        r      = NO_RES;
        ddx    = '{-1, 1, 0, 0};     // left, right, up, down
        ddy    = '{0, 0, -1, 1};
        n_cand = 0;
        n_open = 0;
        if (k == KIND_START)
        begin
            cx = int'({sx[4:1], 1'b0});
            cy = int'({sy[4:1], 1'b0});
            if (cx >= GW)
            begin
                cx = (cx % GW) & ~1;
            end
            if (cy >= GH)
            begin
                cy = (cy % GH) & ~1;
            end
            for (int i = 0; i < CELLS; i++)
            begin
                wall_m[i] = 1'b1;
                seen_m[i] = 1'b0;
            end
            stk_lvl = 0;
            stack_push(cx, cy);
            return r;
        end
        if (stk_lvl == 0)
        begin
            return r;
        end
        stk_lvl--;
        cx          = stk_x[stk_lvl];
        cy          = stk_y[stk_lvl];
        r.running   = 1'b1;
        r.cell_x    = 5'(cx);
        r.cell_y    = 5'(cy);
        if (in_grid(cx, cy))
        begin
            wall_m[cy * GW + cx] = 1'b0;
        end
        for (int d = 0; d < 4; d++)
        begin
            nx = cx + 2 * ddx[d];
            ny = cy + 2 * ddy[d];
            mx = cx + ddx[d];
            my = cy + ddy[d];
            if (in_grid(nx, ny) && !seen_m[ny * GW + nx])
            begin
                cand_x[n_cand] = nx;
                cand_y[n_cand] = ny;
                mid_x[n_cand]  = mx;
                mid_y[n_cand]  = my;
                n_cand++;
            end
            // off-grid neighbours count as wall
            if (in_grid(mx, my) && !wall_m[my * GW + mx])
            begin
                n_open++;
            end
        end
        if (in_grid(cx, cy))
        begin
            seen_m[cy * GW + cx] = 1'b1;
        end
        if (n_cand != 0)
        begin
            pick = int'(rnd) % n_cand;
            if (in_grid(mid_x[pick], mid_y[pick]))
            begin
                wall_m[mid_y[pick] * GW + mid_x[pick]] = 1'b0;
            end
            stack_push(cx, cy);
            stack_push(cand_x[pick], cand_y[pick]);
            r.carved    = 1'b1;
            r.passage_x = 5'(mid_x[pick]);
            r.passage_y = 5'(mid_y[pick]);
        end
        else if (n_open == 1)
        begin
            r.true_endpoint = 1'b1;
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what, int want_v, int got_v);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("MISMATCH %s: expected %0d, got %0d", what, want_v, got_v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * LIMIT_CYC);
        $display("maze_backtracker_carver test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        carve_res_t want;
        if (rst_n && done)
        begin
            if (carve_q.size() == 0)
            begin
                note_mismatch("unexpected result beat, outstanding", 0, 1);
            end
            else
            begin
                want = carve_q.pop_front();
                if (want.running != running)
                    note_mismatch("running", want.running, running);
                if (want.cell_x != cell_x)
                    note_mismatch("cell_x", want.cell_x, cell_x);
                if (want.cell_y != cell_y)
                    note_mismatch("cell_y", want.cell_y, cell_y);
                if (want.carved != carved)
                    note_mismatch("carved", want.carved, carved);
                if (want.passage_x != passage_x)
                    note_mismatch("passage_x", want.passage_x, passage_x);
                if (want.passage_y != passage_y)
                    note_mismatch("passage_y", want.passage_y, passage_y);
                if (want.true_endpoint != true_endpoint)
                    note_mismatch("true_endpoint", want.true_endpoint, true_endpoint);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    // Inputs move on the falling edge. start is only lowered when a gap is
    // drawn, so back-to-back beats keep it high without a glitch. The beat
    // is taken at the first rising edge that sees busy low.
    task automatic send_beat(logic k, logic [4:0] sx, logic [4:0] sy,
                             logic [7:0] rnd, bit typed, carve_res_t want);
        int gap;
        carve_res_t got;
        if (beats_sent % 40 == 0)
        begin
            quiet_run = ($urandom_range(0, 3) == 0);
        end
        gap = quiet_run ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start        <= 1'b1;
        kind         <= k;
        start_x      <= sx;
        start_y      <= sy;
        random_value <= rnd;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        got = carve_predict(k, sx, sy, rnd);
        carve_q = {carve_q, (typed ? want : got)};
        beats_sent++;
    endtask

    // hold the command side off until every owed result has come back
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (carve_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic rand_beat(logic k);
        send_beat(k, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)), 1'b0, NO_RES);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int maze_no;
        int steps;
        int abort_at;
        start        = 1'b0;
        kind         = KIND_STEP;
        start_x      = '0;
        start_y      = '0;
        random_value = '0;
        rst_n        = 1'b0;
        mismatches   = 0;
        beats_sent   = 0;
        quiet_run    = 1'b0;
        stk_lvl      = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            wall_m[i] = 1'b1;
            seen_m[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_beat(dir_rows[i].kind, dir_rows[i].sx, dir_rows[i].sy,
                      dir_rows[i].rnd, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random part: mostly whole mazes carved to the end (stack empty,
        // dead ends and backtracking), some cut short by a fresh start, the
        // odd restart mid-maze and a few steps on an empty stack.
        maze_no = 0;
        while (beats_sent < N_ITEMS)
        begin
            if (maze_no % 2 == 1)
            begin
                drain_results();
            end
            rand_beat(KIND_START);
            maze_no++;
            abort_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 400) : 1 << 30;
            steps    = 0;
            while (stk_lvl != 0 && steps < abort_at && beats_sent < N_ITEMS)
            begin
                rand_beat(($urandom_range(0, 199) == 0) ? KIND_START : KIND_STEP);
                steps++;
            end
            repeat ($urandom_range(0, 3))
            begin
                rand_beat(KIND_STEP);
            end
        end

        // let the last results arrive, then a short settling window
        @(negedge clk);
        start <= 1'b0;
        while (carve_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("maze_backtracker_carver test passed");
        end
        else
        begin
            $display("maze_backtracker_carver test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mbc_pkg.sv
src/mbc_bit_ram.sv
src/mbc_stack.sv
src/maze_backtracker_carver.sv
verif/tb.sv
